FILE: rtl/pgmb_pkg.sv
`default_nettype none

package pgmb_pkg;

  localparam int MM_W       = 20;
  localparam int RANGE_W    = 19;
  localparam int DIV_W      = 13;
  localparam int PIX_W      = 12;
  localparam int GRID_SEL_W = 5;
  localparam int SQ_W       = 40;
  localparam int CELL_IDX_W = 16;

  typedef logic signed [MM_W-1:0] mm_t;

  typedef struct packed {
    mm_t x;
    mm_t y;
    mm_t z;
  } point_t;

  typedef struct packed {
    point_t minimum;
    point_t maximum;
  } cell_t;

  typedef enum logic {
    CMD_ACCUM = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                  command;
    mm_t                   point_x;
    mm_t                   point_y;
    mm_t                   point_z;
    logic [PIX_W-1:0]      pixel_row;
    logic [PIX_W-1:0]      pixel_col;
    logic                  point_ok;
    logic [GRID_SEL_W-1:0] read_row;
    logic [GRID_SEL_W-1:0] read_col;
  } item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_min_mm;
    logic [RANGE_W-1:0] range_max_mm;
    logic [DIV_W-1:0]   rows_per_cell;
    logic [DIV_W-1:0]   cols_per_cell;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_ROWS      = 2'd2,
    REG_COLS      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ACCUM    = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_OFF = 2'd2
  } job_op_t;

  typedef struct packed {
    job_op_t               op;
    logic [CELL_IDX_W-1:0] idx;
    point_t                pt;
  } job_t;

  typedef struct packed {
    point_t minimum;
    point_t maximum;
    point_t center;
    logic   valid;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_CALC = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  typedef enum logic [1:0] {
    B_INIT  = 2'd0,
    B_IDLE  = 2'd1,
    B_MERGE = 2'd2
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/pgmb_front.sv
`default_nettype none

module pgmb_front #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  pgmb_pkg::cfg_t    cfg,
  input  wire               in_valid,
  output logic              in_ready,
  input  pgmb_pkg::item_t   in_item,
  output logic              job_valid,
  input  wire               job_ready,
  output pgmb_pkg::job_t    job
);
  import pgmb_pkg::*;

  localparam int CNT_W = $clog2(PIX_W);

  front_state_t state, state_next;

  item_t            cur;
  logic [DIV_W-1:0] div_r, div_c;
  logic [PIX_W-1:0] num_r, num_c;
  logic [DIV_W-1:0] rem_r, rem_c;
  logic [PIX_W-1:0] q_r, q_c;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  sq_x, sq_y, sq_z, norm, lo2, hi2;

  logic [DIV_W:0]   tmp_r, tmp_c;
  logic             last_step;
  logic             in_range;
  logic             keep;
  logic             read_on_grid;
  logic             accept;

  assign accept    = in_valid && in_ready;
  assign last_step = (cnt == CNT_W'(PIX_W - 1));
  assign tmp_r     = {rem_r, num_r[PIX_W-1]};
  assign tmp_c     = {rem_c, num_c[PIX_W-1]};

  assign in_range     = !((norm < lo2) || (norm > hi2));
  assign read_on_grid = (32'(cur.read_row) < GRID_ROWS) && (32'(cur.read_col) < GRID_COLS);
  assign keep         = cur.point_ok && in_range &&
                        (32'(q_r) < GRID_ROWS) && (32'(q_c) < GRID_COLS);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_CALC;
      F_CALC: if (last_step) state_next = F_PUSH;
      F_PUSH: begin
        if ((cur.command == CMD_ACCUM) && !keep) state_next = F_IDLE;
        else if (job_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == F_IDLE) && en;
    job_valid = (state == F_PUSH) && ((cur.command == CMD_READ) || keep);
    job.pt    = '{x: cur.point_x, y: cur.point_y, z: cur.point_z};
    if (cur.command == CMD_READ) begin
      job.op  = read_on_grid ? OP_READ : OP_READ_OFF;
      job.idx = CELL_IDX_W'(32'(cur.read_row) * GRID_COLS + 32'(cur.read_col));
    end else begin
      job.op  = OP_ACCUM;
      job.idx = CELL_IDX_W'(32'(q_r) * GRID_COLS + 32'(q_c));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    lo2  <= cfg.range_min_mm * cfg.range_min_mm;
    hi2  <= cfg.range_max_mm * cfg.range_max_mm;
    sq_x <= cur.point_x * cur.point_x;
    sq_y <= cur.point_y * cur.point_y;
    sq_z <= cur.point_z * cur.point_z;
    norm <= sq_x + sq_y + sq_z;
    if (accept) begin
      cur   <= in_item;
      num_r <= in_item.pixel_row;
      num_c <= in_item.pixel_col;
      div_r <= (cfg.rows_per_cell == '0) ? DIV_W'(1) : cfg.rows_per_cell;
      div_c <= (cfg.cols_per_cell == '0) ? DIV_W'(1) : cfg.cols_per_cell;
      rem_r <= '0;
      rem_c <= '0;
      q_r   <= '0;
      q_c   <= '0;
      cnt   <= '0;
    end else if (state == F_CALC) begin
      num_r <= {num_r[PIX_W-2:0], 1'b0};
      num_c <= {num_c[PIX_W-2:0], 1'b0};
      cnt   <= cnt + CNT_W'(1);
      if (tmp_r >= {1'b0, div_r}) begin
        rem_r <= DIV_W'(tmp_r - {1'b0, div_r});
        q_r   <= {q_r[PIX_W-2:0], 1'b1};
      end else begin
        rem_r <= tmp_r[DIV_W-1:0];
        q_r   <= {q_r[PIX_W-2:0], 1'b0};
      end
      if (tmp_c >= {1'b0, div_c}) begin
        rem_c <= DIV_W'(tmp_c - {1'b0, div_c});
        q_c   <= {q_c[PIX_W-2:0], 1'b1};
      end else begin
        rem_c <= tmp_c[DIV_W-1:0];
        q_c   <= {q_c[PIX_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pgmb_queue.sv
`default_nettype none

module pgmb_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  pgmb_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  wire             rd_ready,
  output pgmb_pkg::job_t  rd_data
);
  import pgmb_pkg::*;

  job_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      if (do_wr && !do_rd) count <= count + 2'd1;
      else if (do_rd && !do_wr) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: rtl/pgmb_back.sv
`default_nettype none

module pgmb_back #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  wire                clk,
  input  wire                rst,
  output logic               init_done,
  input  wire                job_valid,
  output logic               job_ready,
  input  pgmb_pkg::job_t     job,
  output logic               out_valid,
  input  wire                out_ready,
  output pgmb_pkg::result_t  out_data
);
  import pgmb_pkg::*;

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam mm_t    MM_MOST_POS = {1'b0, {(MM_W-1){1'b1}}};
  localparam mm_t    MM_MOST_NEG = {1'b1, {(MM_W-1){1'b0}}};
  localparam point_t ALL_POS     = '{x: MM_MOST_POS, y: MM_MOST_POS, z: MM_MOST_POS};
  localparam point_t ALL_NEG     = '{x: MM_MOST_NEG, y: MM_MOST_NEG, z: MM_MOST_NEG};
  localparam cell_t  EMPTY_CELL  = '{minimum: ALL_POS, maximum: ALL_NEG};

  function automatic mm_t mid_floor(mm_t lo, mm_t hi);
    logic signed [MM_W:0] s;
    s = {lo[MM_W-1], lo} + {hi[MM_W-1], hi};
    return s[MM_W:1];
  endfunction

  back_state_t state, state_next;

  cell_t mem [CELLS];
  cell_t rdata;
  cell_t wdata;
  logic  we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] clr_cnt;
  logic [ADDR_W-1:0] cur_idx;
  job_op_t cur_op;
  point_t  cur_pt;
  cell_t   merged;
  result_t res;
  logic    hit, same;

  assign init_done = (state != B_INIT);

  always_comb begin
    merged.minimum.x = (cur_pt.x < rdata.minimum.x) ? cur_pt.x : rdata.minimum.x;
    merged.minimum.y = (cur_pt.y < rdata.minimum.y) ? cur_pt.y : rdata.minimum.y;
    merged.minimum.z = (cur_pt.z < rdata.minimum.z) ? cur_pt.z : rdata.minimum.z;
    merged.maximum.x = (cur_pt.x > rdata.maximum.x) ? cur_pt.x : rdata.maximum.x;
    merged.maximum.y = (cur_pt.y > rdata.maximum.y) ? cur_pt.y : rdata.maximum.y;
    merged.maximum.z = (cur_pt.z > rdata.maximum.z) ? cur_pt.z : rdata.maximum.z;

    hit  = (rdata.minimum.x <= rdata.maximum.x);
    same = (rdata.minimum == rdata.maximum);
    res  = '0;
    if (cur_op == OP_READ) begin
      res.minimum = rdata.minimum;
      res.maximum = rdata.maximum;
      res.valid   = hit && !same;
      if (hit && !same) begin
        res.center.x = mid_floor(rdata.minimum.x, rdata.maximum.x);
        res.center.y = mid_floor(rdata.minimum.y, rdata.maximum.y);
        res.center.z = mid_floor(rdata.minimum.z, rdata.maximum.z);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_INIT:  if (clr_cnt == ADDR_W'(CELLS - 1)) state_next = B_IDLE;
      B_IDLE:  if (job_ready) state_next = B_MERGE;
      B_MERGE: state_next = B_IDLE;
      default: state_next = B_INIT;
    endcase
  end

  always_comb begin
    job_ready = 1'b0;
    we        = 1'b0;
    waddr     = cur_idx;
    wdata     = EMPTY_CELL;
    unique case (state)
      B_INIT: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      B_IDLE: job_ready = job_valid && ((job.op == OP_ACCUM) || !out_valid);
      B_MERGE: begin
        we    = (cur_op != OP_READ_OFF);
        wdata = (cur_op == OP_ACCUM) ? merged : EMPTY_CELL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_INIT) clr_cnt <= clr_cnt + ADDR_W'(1);
      if (state == B_MERGE && cur_op != OP_ACCUM) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      cur_op  <= job.op;
      cur_idx <= job.idx[ADDR_W-1:0];
      cur_pt  <= job.pt;
    end
    if (state == B_MERGE && cur_op != OP_ACCUM) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[job.idx[ADDR_W-1:0]];
  end

  a_no_pop_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == B_INIT) |-> !job_ready)
    else $error("job taken during clearing pass");

  a_pop_to_merge: assert property (@(posedge clk) disable iff (rst)
    job_ready |=> (state == B_MERGE))
    else $error("popped job not merged next cycle");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == B_MERGE && cur_op != OP_ACCUM) |=> out_valid)
    else $error("read job produced no result");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    (job_ready && job.op != OP_ACCUM) |-> !out_valid)
    else $error("read job popped while result pending");

endmodule

`default_nettype wire

FILE: rtl/point_grid_min_max_binning_core.sv
// Per-cell bounding-box binning of an organized point cloud.
// Input stream (s_*): one item per point or read request. tuser carries the
// command (0 accumulate, 1 read and clear). Output stream (m_*): one item per
// read request with the cell's box, centre and valid flag; none per point.
// APB port: range_min_mm at 0x0, range_max_mm at 0x4, rows_per_cell at 0x8,
// cols_per_cell at 0xC; write only while the block is idle.
// Front: one item at a time; it loads each item, runs its bit-serial row and
// column dividers (12 steps), then hands off any job, stalling on a full queue.
// A read's result is registered onto m_tvalid from the back end's B_MERGE state.
// The back end read-modify-writes a cell: read at the pop, written in B_MERGE.
// Reset: a clearing pass over all GRID_ROWS*GRID_COLS cells (1024 by default)
// empties every cell; s_tready stays low until it ends. APB writes are taken.
// Stall: a held result stalls a read at the queue head and all jobs behind it;
// the front keeps taking items into the 2-entry queue until it fills, then s_tready drops.
`default_nettype none

module point_grid_min_max_binning_core #(
  parameter int GRID_ROWS = 32,
  parameter int GRID_COLS = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, pixel_row, pixel_col, point_ok, read_row, read_col
  input  wire  [95:0]  s_tdata,
  // command
  input  wire          s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // box_min_x/y/z, box_max_x/y/z, center_x/y/z, box_valid
  output logic [183:0] m_tdata,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [3:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pgmb_pkg::*;

  cfg_t    cfg;
  item_t   item;
  job_t    fj, qj;
  logic    fj_valid, fj_ready, qj_valid, qj_ready;
  logic    init_done;
  result_t res;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_min_mm  <= '0;
      cfg.range_max_mm  <= '1;
      cfg.rows_per_cell <= DIV_W'(1);
      cfg.cols_per_cell <= DIV_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_RANGE_MIN: cfg.range_min_mm  <= pwdata[RANGE_W-1:0];
        REG_RANGE_MAX: cfg.range_max_mm  <= pwdata[RANGE_W-1:0];
        REG_ROWS:      cfg.rows_per_cell <= pwdata[DIV_W-1:0];
        REG_COLS:      cfg.cols_per_cell <= pwdata[DIV_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_RANGE_MIN: prdata = 32'(cfg.range_min_mm);
      REG_RANGE_MAX: prdata = 32'(cfg.range_max_mm);
      REG_ROWS:      prdata = 32'(cfg.rows_per_cell);
      REG_COLS:      prdata = 32'(cfg.cols_per_cell);
    endcase
  end

  always_comb begin
    item.command   = s_tuser;
    item.point_x   = s_tdata[19:0];
    item.point_y   = s_tdata[39:20];
    item.point_z   = s_tdata[59:40];
    item.pixel_row = s_tdata[71:60];
    item.pixel_col = s_tdata[83:72];
    item.point_ok  = s_tdata[84];
    item.read_row  = s_tdata[89:85];
    item.read_col  = s_tdata[94:90];
  end

  pgmb_front #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (init_done),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  pgmb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj),
    .rd_valid (qj_valid),
    .rd_ready (qj_ready),
    .rd_data  (qj)
  );

  pgmb_back #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .init_done (init_done),
    .job_valid (qj_valid),
    .job_ready (qj_ready),
    .job       (qj),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {3'b000, res.valid,
                    res.center.z, res.center.y, res.center.x,
                    res.maximum.z, res.maximum.y, res.maximum.x,
                    res.minimum.z, res.minimum.y, res.minimum.x};

endmodule

`default_nettype wire
